@@ hw/rtl/ssnp_pkg.sv @@
package ssnp_pkg;

	// Register file geometry; the index width is fixed by the reg_index field.
	localparam int unsigned RF_DEPTH = 16;
	localparam int unsigned RF_AW    = 4;
	localparam int unsigned XLEN     = 32;

	// Input word layout on s_tdata, lowest field first, padded to whole bytes.
	localparam int unsigned IN_DATA_W  = 136;
	localparam int unsigned OUT_DATA_W = 32;

	// Item kinds carried in s_tuser.
	localparam logic ACT_WRITE   = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// Register file write request.
	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] addr;
		logic [XLEN-1:0]  data;
	} rf_wr_t;

	// Register file read request, two ports.
	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] addr_a;
		logic [RF_AW-1:0] addr_b;
	} rf_rd_t;

endpackage

@@ hw/rtl/ssnp_regfile.sv @@
module ssnp_regfile
	import ssnp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  rf_wr_t          wr,
	input  rf_rd_t          rd,
	output logic [XLEN-1:0] rd_data_a,
	output logic [XLEN-1:0] rd_data_b
);

	logic [XLEN-1:0]     mem [RF_DEPTH];
	logic [RF_DEPTH-1:0] vld_q;
	logic [XLEN-1:0]     rd_a_q;
	logic [XLEN-1:0]     rd_b_q;

	// Storage array: one write port, no reset.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Written flags; an entry not yet written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_a_q <= vld_q[rd.addr_a] ? mem[rd.addr_a] : '0;
			rd_b_q <= vld_q[rd.addr_b] ? mem[rd.addr_b] : '0;
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

@@ hw/rtl/ssnp_next.sv @@
module ssnp_next
	import ssnp_pkg::*;
(
	input  logic [XLEN-1:0] word,
	input  logic [XLEN-1:0] pc,
	input  logic            cond,
	input  logic [XLEN-1:0] ret_pc,
	input  logic [XLEN-1:0] reg_a,
	input  logic [XLEN-1:0] reg_b,
	output logic [XLEN-1:0] next_pc
);

	localparam logic [3:0] OP_S_BRANCH = 4'h7;
	localparam logic [3:0] OP_S_MISC   = 4'h1;
	localparam logic [3:0] OP2_S_RTE   = 4'h0;
	localparam logic [3:0] OP3_S_RTE   = 4'hd;
	localparam logic [3:0] OP3_S_JMP   = 4'hc;
	localparam logic [3:0] OP_L_BRANCH = 4'hf;
	localparam logic [3:0] OP_L_CMP    = 4'hb;

	localparam logic [3:0] SEL_NC0 = 4'h9;
	localparam logic [3:0] SEL_NC1 = 4'hd;
	localparam logic [3:0] SEL_C0  = 4'h8;
	localparam logic [3:0] SEL_C1  = 4'hc;
	localparam logic [3:0] SEL_AL0 = 4'he;
	localparam logic [3:0] SEL_AL1 = 4'hf;

	localparam logic [3:0] CMP_EQ  = 4'h0;
	localparam logic [3:0] CMP_NE  = 4'h1;
	localparam logic [3:0] CMP_EQZ = 4'h8;
	localparam logic [3:0] CMP_NEZ = 4'h9;
	localparam logic [3:0] CMP_LTZ = 4'ha;
	localparam logic [3:0] CMP_GEZ = 4'hb;
	localparam logic [3:0] CMP_LEZ = 4'hc;
	localparam logic [3:0] CMP_GTZ = 4'hd;

	// Condition rule shared by the short and long pc-relative branches.
	function automatic logic branch_taken(input logic [3:0] sel, input logic c);
		logic t;
		unique case (sel)
			SEL_NC0, SEL_NC1: t = !c;
			SEL_C0, SEL_C1:   t = c;
			SEL_AL0, SEL_AL1: t = 1'b1;
			default:          t = 1'b0;
		endcase
		return t;
	endfunction

	logic            is_long;
	logic [15:0]     hw;
	logic [3:0]      s_op, s_op2, s_op3, l_op, l_op2, l_sel;
	logic            b_neg, b_zero, cmp_take, jmp_take;
	logic [XLEN-1:0] base, addend, sum;
	logic            use_sum;

	// Halfword pick: an address with either low bit set uses the low half.
	always_comb begin
		is_long = word[31];
		hw      = (pc[1:0] != 2'b00) ? {1'b0, word[14:0]} : word[31:16];
		s_op    = hw[15:12];
		s_op2   = hw[11:8];
		s_op3   = hw[7:4];
		l_op    = word[31:28];
		l_op2   = word[27:24];
		l_sel   = word[23:20];
		b_neg   = reg_b[31];
		b_zero  = (reg_b == '0);
		jmp_take = ((s_op2 == SEL_C1) && cond) || ((s_op2 == SEL_NC1) && !cond) ||
			(s_op2 == SEL_AL0) || (s_op2 == SEL_AL1);
	end

	// Register compare for the long compare-and-branch form.
	always_comb begin
		unique case (l_sel)
			CMP_EQ:  cmp_take = (reg_a == reg_b);
			CMP_NE:  cmp_take = (reg_a != reg_b);
			CMP_EQZ: cmp_take = b_zero;
			CMP_NEZ: cmp_take = !b_zero;
			CMP_LTZ: cmp_take = b_neg;
			CMP_GEZ: cmp_take = !b_neg;
			CMP_LEZ: cmp_take = b_neg || b_zero;
			CMP_GTZ: cmp_take = !b_neg && !b_zero;
			default: cmp_take = 1'b0;
		endcase
	end

	// Decode into one add or a direct target.
	always_comb begin
		base    = pc;
		addend  = word[15] ? XLEN'(4) : XLEN'(2);
		use_sum = 1'b1;
		next_pc = '0;
		if (is_long) begin
			addend = XLEN'(4);
			if ((l_op == OP_L_BRANCH) && branch_taken(l_op2, cond)) begin
				base   = {pc[XLEN-1:2], 2'b00};
				addend = {{6{word[23]}}, word[23:0], 2'b00};
			end else if ((l_op == OP_L_CMP) && cmp_take) begin
				base   = {pc[XLEN-1:2], 2'b00};
				addend = {{14{word[15]}}, word[15:0], 2'b00};
			end
		end else begin
			if ((s_op == OP_S_BRANCH) && branch_taken(s_op2, cond)) begin
				base   = {pc[XLEN-1:2], 2'b00};
				addend = {{22{hw[7]}}, hw[7:0], 2'b00};
			end else if ((s_op == OP_S_MISC) && (s_op2 == OP2_S_RTE) &&
				(s_op3 == OP3_S_RTE)) begin
				use_sum = 1'b0;
				next_pc = ret_pc;
			end else if ((s_op == OP_S_MISC) && (s_op2 != OP2_S_RTE) &&
				(s_op3 == OP3_S_JMP) && jmp_take) begin
				use_sum = 1'b0;
				next_pc = reg_a;
			end
		end
		sum = base + addend;
		if (use_sum) begin
			next_pc = sum;
		end
	end

endmodule

@@ hw/rtl/single_step_next_pc_top.sv @@
// Next-pc unit for single stepping a mixed 16/32-bit instruction stream.
// Input words arrive on s_tvalid/s_tready/s_tdata with the item kind on
// s_tuser[0]: a write word loads one of the 16 general registers, a compute
// word carries the fetched aligned instruction word, pc, condition bit and
// saved return pc. Each compute word gives one result word on m_tdata
// (next pc) with m_tuser[0] flagging a target with bit 31 set; write words
// give no result.
// A compute word reads its two register operands from the register file
// memory at the edge that accepts it; the next pc is formed from the
// registered read data and lands in the output register when the read stage
// advances. One word is accepted per cycle while the output register
// drains; the registered memory read and the single decode stage set
// that rate.
// Reset clears the written flags of the register file at once, so every
// register reads as zero with no clearing pass, and empties the pipeline.
// When the receiver stalls, the result holds in the output register, one
// more compute word waits in the read stage, and s_tready drops.
module single_step_next_pc_top
	import ssnp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// reg_index[3:0], reg_value[35:4], instruction[67:36], pc[99:68],
	// cond_bit[100], return_pc[132:101], zero padding
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action[0]
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// next_pc[31:0]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// beyond_user[0]
	output logic [0:0]            m_tuser
);

	logic [RF_AW-1:0] in_reg_index;
	logic [XLEN-1:0]  in_reg_value, in_word, in_pc, in_ret;
	logic             in_cond, in_accept, s1_adv;
	logic [RF_AW-1:0] addr_a;
	rf_wr_t           rf_wr;
	rf_rd_t           rf_rd;
	logic [XLEN-1:0]  reg_a, reg_b, calc_pc;

	logic             vld_s1;
	logic [XLEN-1:0]  word_s1, pc_s1, ret_s1;
	logic             cond_s1;
	logic             out_vld_q;
	logic [XLEN-1:0]  out_pc_q;

	// Unpack the input word.
	assign in_reg_index = s_tdata[3:0];
	assign in_reg_value = s_tdata[35:4];
	assign in_word      = s_tdata[67:36];
	assign in_pc        = s_tdata[99:68];
	assign in_cond      = s_tdata[100];
	assign in_ret       = s_tdata[132:101];

	// Handshake: the read stage moves on whenever the output register is free.
	assign s1_adv    = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || s1_adv;
	assign in_accept = s_tvalid && s_tready;

	// Operand A is the long form ra, or the register of a short jump in
	// whichever halfword the pc selects.
	always_comb begin
		if (in_word[31]) begin
			addr_a = in_word[27:24];
		end else if (in_pc[1:0] != 2'b00) begin
			addr_a = in_word[3:0];
		end else begin
			addr_a = in_word[19:16];
		end
		rf_wr.en     = in_accept && (s_tuser[0] == ACT_WRITE);
		rf_wr.addr   = in_reg_index;
		rf_wr.data   = in_reg_value;
		rf_rd.en     = in_accept && (s_tuser[0] == ACT_COMPUTE);
		rf_rd.addr_a = addr_a;
		rf_rd.addr_b = in_word[19:16];
	end

	ssnp_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rf_wr),
		.rd        (rf_rd),
		.rd_data_a (reg_a),
		.rd_data_b (reg_b)
	);

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rf_rd.en) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Read stage payload, captured alongside the register read.
	always_ff @(posedge clk) begin
		if (rf_rd.en) begin
			word_s1 <= in_word;
			pc_s1   <= in_pc;
			cond_s1 <= in_cond;
			ret_s1  <= in_ret;
		end
	end

	ssnp_next u_next (
		.word    (word_s1),
		.pc      (pc_s1),
		.cond    (cond_s1),
		.ret_pc  (ret_s1),
		.reg_a   (reg_a),
		.reg_b   (reg_b),
		.next_pc (calc_pc)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pc_q <= calc_pc;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_pc_q;
	assign m_tuser[0] = out_pc_q[31];

`ifndef ASSERT_OFF
	// A compute word in the read stage is not dropped while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && out_vld_q && !m_tready |=> vld_s1)
		else $error("read stage word lost under output stall");

	// A register write into an empty pipeline never makes a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (s_tuser[0] == ACT_WRITE) && !vld_s1 && !out_vld_q |=> !m_tvalid)
		else $error("register write produced a result");

	// The read stage is never overwritten while it still holds a word.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_adv |-> !s_tready)
		else $error("input accepted over a stalled read stage");
`endif

endmodule

@@ tb/sv/tb_single_step_next_pc_top.sv @@
`timescale 1ns / 1ps

module tb_single_step_next_pc_top;
	import ssnp_pkg::*;

	// Opcode and selector codes of the instruction set.
	localparam logic [3:0] OP16_BRANCH  = 4'h7;
	localparam logic [3:0] OP16_SPECIAL = 4'h1;
	localparam logic [3:0] SUB_NONE     = 4'h0;
	localparam logic [3:0] SUB_RTE      = 4'hd;
	localparam logic [3:0] SUB_JUMP     = 4'hc;
	localparam logic [3:0] SUB_TRAP     = 4'hf;
	localparam logic [3:0] OP32_BRANCH  = 4'hf;
	localparam logic [3:0] OP32_CMPBR   = 4'hb;

	localparam logic [3:0] BR_IF_SET_A  = 4'h8;
	localparam logic [3:0] BR_IF_CLR_A  = 4'h9;
	localparam logic [3:0] BR_IF_SET_B  = 4'hc;
	localparam logic [3:0] BR_IF_CLR_B  = 4'hd;
	localparam logic [3:0] BR_ALWAYS_A  = 4'he;
	localparam logic [3:0] BR_ALWAYS_B  = 4'hf;

	localparam logic [3:0] JMP_IF_SET   = 4'hc;
	localparam logic [3:0] JMP_IF_CLR   = 4'hd;
	localparam logic [3:0] JMP_ALWAYS_A = 4'he;
	localparam logic [3:0] JMP_ALWAYS_B = 4'hf;

	localparam logic [3:0] CMP_EQ  = 4'h0;
	localparam logic [3:0] CMP_NE  = 4'h1;
	localparam logic [3:0] CMP_EQZ = 4'h8;
	localparam logic [3:0] CMP_NEZ = 4'h9;
	localparam logic [3:0] CMP_LTZ = 4'ha;
	localparam logic [3:0] CMP_GEZ = 4'hb;
	localparam logic [3:0] CMP_LEZ = 4'hc;
	localparam logic [3:0] CMP_GTZ = 4'hd;

	localparam int unsigned RANDOM_WORDS = 1325;
	localparam int unsigned DIRECTED_ROWS = 25;
	localparam int unsigned CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic        action;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic [31:0] instruction;
		logic [31:0] pc;
		logic        cond_bit;
		logic [31:0] return_pc;
	} step_word_t;

	typedef struct packed {
		step_word_t  w;
		logic        typed;
		logic [31:0] typed_pc;
	} directed_row_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        beyond_user;
	} next_pc_result_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HOLD, RX_ALTERNATE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	logic [31:0]     gpr_shadow [RF_DEPTH];
	next_pc_result_t pending_next_pc [$];
	logic            cur_typed = 1'b0;
	logic [31:0]     cur_typed_pc = '0;

	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned n_writes = 0;
	int unsigned n_computes = 0;
	int unsigned n_checked = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;

	// Directed rows: reset state and extremes carry a typed next pc.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h00000000, 32'h00000000, 1'b0, 32'h0}, 1'b1, 32'h00000002},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h00000000, 32'hfffffffe, 1'b0, 32'h0}, 1'b1, 32'h00000000},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h00008000, 32'h00000100, 1'b0, 32'h0}, 1'b1, 32'h00000104},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h80000000, 32'hfffffffc, 1'b0, 32'h0}, 1'b1, 32'h00000000},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h10d00000, 32'h00002000, 1'b0, 32'h80001234},
			1'b1, 32'h80001234},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h10f00000, 32'h00002000, 1'b1, 32'h0}, 1'b1, 32'h00002002},
		'{'{ACT_WRITE, 4'h3, 32'hffffffff, 32'h0, 32'h0, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_WRITE, 4'hf, 32'h80000001, 32'h0, 32'h0, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_WRITE, 4'h7, 32'h7fffffff, 32'h0, 32'h0, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h7e800000, 32'h00001000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h78010000, 32'h00001000, 1'b1, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h00007d7f, 32'h00001003, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h0000fc80, 32'h00001002, 1'b1, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h1ec30000, 32'h00003000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h1ccf0000, 32'h00003000, 1'b1, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'h00001fc7, 32'h00003002, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hff800000, 32'h00000000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hf87fffff, 32'hfffffffc, 1'b1, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb3038000, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb0137fff, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb0af0004, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb0800010, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb0d70020, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb0c3fff0, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0},
		'{'{ACT_COMPUTE, 4'h0, 32'h0, 32'hb0bf0040, 32'h00004000, 1'b0, 32'h0}, 1'b0, 32'h0}
	};

	single_step_next_pc_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Word-aligned pc plus a sign-extended displacement scaled by four.
	function automatic logic [31:0] pc_rel(input logic [31:0] pc, input logic [31:0] disp);
		return {pc[31:2], 2'b00} + {disp[29:0], 2'b00};
	endfunction

	// Condition rule shared by the short and long pc-relative branches.
	function automatic logic branch_rule(input logic [3:0] sel, input logic cond);
		case (sel)
			BR_IF_CLR_A, BR_IF_CLR_B: return !cond;
			BR_IF_SET_A, BR_IF_SET_B: return cond;
			BR_ALWAYS_A, BR_ALWAYS_B: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [31:0] predict_next_pc(input step_word_t w);
		logic [15:0] h;
		logic [3:0]  op;
		logic [3:0]  op2;
		logic [3:0]  op3;
		logic [31:0] a;
		logic [31:0] b;
		logic        hit;
		if (w.instruction[31]) begin
			op = w.instruction[31:28];
			if (op == OP32_BRANCH && branch_rule(w.instruction[27:24], w.cond_bit))
				return pc_rel(w.pc, {{8{w.instruction[23]}}, w.instruction[23:0]});
			if (op == OP32_CMPBR) begin
				a = gpr_shadow[w.instruction[27:24]];
				b = gpr_shadow[w.instruction[19:16]];
				case (w.instruction[23:20])
					CMP_EQ:  hit = (a == b);
					CMP_NE:  hit = (a != b);
					CMP_EQZ: hit = (b == 32'h0);
					CMP_NEZ: hit = (b != 32'h0);
					CMP_LTZ: hit = b[31];
					CMP_GEZ: hit = !b[31];
					CMP_LEZ: hit = b[31] || (b == 32'h0);
					CMP_GTZ: hit = !b[31] && (b != 32'h0);
					default: hit = 1'b0;
				endcase
				if (hit)
					return pc_rel(w.pc, {{16{w.instruction[15]}}, w.instruction[15:0]});
			end
			return w.pc + 32'd4;
		end
		// Any nonzero low pc bits select the low halfword, odd pc included.
		h = (w.pc[1:0] != 2'b00) ? {1'b0, w.instruction[14:0]} : w.instruction[31:16];
		op = h[15:12];
		op2 = h[11:8];
		op3 = h[7:4];
		if (op == OP16_BRANCH && branch_rule(op2, w.cond_bit))
			return pc_rel(w.pc, {{24{h[7]}}, h[7:0]});
		if (op == OP16_SPECIAL && op2 == SUB_NONE && op3 == SUB_RTE)
			return w.return_pc;
		if (op == OP16_SPECIAL && op2 != SUB_NONE && op3 == SUB_JUMP) begin
			hit = (op2 == JMP_IF_SET && w.cond_bit) || (op2 == JMP_IF_CLR && !w.cond_bit) ||
				op2 == JMP_ALWAYS_A || op2 == JMP_ALWAYS_B;
			if (hit)
				return gpr_shadow[h[3:0]];
		end
		return w.pc + (w.instruction[15] ? 32'd4 : 32'd2);
	endfunction

	// Random word: mostly decodable forms with random content, some noise.
	function automatic step_word_t random_step_word();
		step_word_t w;
		logic [15:0] h;
		w.action = ($urandom_range(0, 4) == 0) ? ACT_WRITE : ACT_COMPUTE;
		w.reg_index = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 5))
			0: w.reg_value = 32'h0;
			1: w.reg_value = 32'hffffffff;
			2: w.reg_value = 32'h80000000;
			3: w.reg_value = 32'h7fffffff;
			4: w.reg_value = $urandom_range(0, 3);
			default: w.reg_value = $urandom;
		endcase
		w.cond_bit = 1'($urandom_range(0, 1));
		w.return_pc = $urandom;
		w.pc = $urandom;
		case ($urandom_range(0, 7))
			0: ;
			1: w.pc[31:4] = 28'hfffffff;
			default: w.pc[0] = 1'b0;
		endcase
		w.instruction = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				h = 16'($urandom);
				case ($urandom_range(0, 4))
					0: h[15:12] = OP16_BRANCH;
					1: h[15:4] = {OP16_SPECIAL, SUB_NONE, SUB_RTE};
					2: begin
						h[15:12] = OP16_SPECIAL;
						h[7:4] = SUB_JUMP;
					end
					3: h[15:4] = {OP16_SPECIAL, SUB_NONE, SUB_TRAP};
					default: ;
				endcase
				w.instruction[31] = 1'b0;
				if (w.pc[1:0] == 2'b00)
					w.instruction[30:16] = h[14:0];
				else
					w.instruction[14:0] = h[14:0];
			end
			4, 5: w.instruction[31:28] = OP32_BRANCH;
			6, 7: begin
				w.instruction[31:28] = OP32_CMPBR;
				case ($urandom_range(0, 8))
					0: w.instruction[23:20] = CMP_EQ;
					1: w.instruction[23:20] = CMP_NE;
					2: w.instruction[23:20] = CMP_EQZ;
					3: w.instruction[23:20] = CMP_NEZ;
					4: w.instruction[23:20] = CMP_LTZ;
					5: w.instruction[23:20] = CMP_GEZ;
					6: w.instruction[23:20] = CMP_LEZ;
					7: w.instruction[23:20] = CMP_GTZ;
					default: ;
				endcase
				if ($urandom_range(0, 2) == 0)
					w.instruction[19:16] = w.instruction[27:24];
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch in %s at cycle %0d: got %08h, expected %08h",
			what, cycle_count, got, want);
		err_count++;
	endtask

	// Drive one word at a falling edge and hold it until accepted.
	task automatic send_word(input step_word_t w, input logic typed, input logic [31:0] typed_pc);
		s_tdata <= {3'b000, w.return_pc, w.cond_bit, w.pc, w.instruction, w.reg_value,
			w.reg_index};
		s_tuser <= w.action;
		s_tvalid <= 1'b1;
		cur_typed <= typed;
		cur_typed_pc <= typed_pc;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	// Receiver readiness follows stretches of open, coin-flip, held and alternating cycles.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_OPEN:      m_tready <= 1'b1;
			RX_COIN:      m_tready <= 1'($urandom_range(0, 1));
			RX_HOLD:      m_tready <= 1'b0;
			RX_ALTERNATE: m_tready <= rx_phase[0];
		endcase
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Track accepted input words and check accepted result words.
	always @(posedge clk) begin : monitor
		step_word_t      w;
		next_pc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_next_pc.size() == 0) begin
				report_mismatch("result with no pending request", m_tdata, 32'h0);
			end else begin
				want = pending_next_pc.pop_front();
				n_checked++;
				if (m_tdata !== want.next_pc)
					report_mismatch("next_pc", m_tdata, want.next_pc);
				if (m_tuser[0] !== want.beyond_user)
					report_mismatch("beyond_user", {31'h0, m_tuser[0]}, {31'h0, want.beyond_user});
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			w.action = s_tuser[0];
			w.reg_index = s_tdata[3:0];
			w.reg_value = s_tdata[35:4];
			w.instruction = s_tdata[67:36];
			w.pc = s_tdata[99:68];
			w.cond_bit = s_tdata[100];
			w.return_pc = s_tdata[132:101];
			if (w.action == ACT_WRITE) begin
				gpr_shadow[w.reg_index] = w.reg_value;
				n_writes++;
			end else begin
				want.next_pc = cur_typed ? cur_typed_pc : predict_next_pc(w);
				want.beyond_user = want.next_pc[31];
				pending_next_pc.push_back(want);
				n_computes++;
			end
		end
	end

	initial begin
		foreach (gpr_shadow[i])
			gpr_shadow[i] = 32'h0;
		burst_left = $urandom_range(1, 20);
		repeat (2)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table first.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].typed_pc);

		// Random stream, with a few full drains along the way.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 400 == 200) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (pending_next_pc.size() != 0)
					@(negedge clk);
			end
			send_word(random_step_word(), 1'b0, 32'h0);
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_next_pc.size() != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);

		$display("Covered %0d register writes and %0d next-pc requests, %0d results compared,",
			n_writes, n_computes, n_checked);
		$display("with branches, register jumps, exception returns and sender/receiver stalls.");
		if (err_count == 0 && pending_next_pc.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
